FILE: hdl/wpp_pkg.sv
// Shared types, widths and helpers for the world-to-pixel projection block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wpp_pkg;

  localparam int TRIG_FRAC_BITS  = 16;
  localparam int FOCAL_FRAC_BITS = 8;
  localparam int TERM_W   = TRIG_FRAC_BITS + 2;
  localparam int ACC_W    = 2 * TERM_W + 1;
  localparam int PT_W     = 32;
  localparam int PROD_W   = PT_W + TERM_W;
  localparam int SUM3_W   = PROD_W + 2;
  localparam int ROT_W    = SUM3_W - TRIG_FRAC_BITS;
  localparam int FOCAL_W  = 24;
  localparam int NUM_W    = FOCAL_W + ROT_W + 1;
  localparam int MAG_W    = NUM_W - 1;
  localparam int DEN_W    = ROT_W - 1 + FOCAL_FRAC_BITS;
  localparam int QBITS    = 17;
  localparam int Q_W      = QBITS + 1;
  localparam int DSH_W    = DEN_W + QBITS;
  localparam int DIV_W    = (MAG_W > DSH_W) ? MAG_W : DSH_W;
  localparam int NCELLS   = Q_W;
  localparam int ANG_W    = 16;
  localparam int DIM_W    = 14;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 3;

  typedef logic signed [TERM_W-1:0] term_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ROLL   = 3'd0,
    REG_PITCH  = 3'd1,
    REG_YAW    = 3'd2,
    REG_FOCALX = 3'd3,
    REG_FOCALY = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } reg_idx_t;

  // One divider cell's view of a transaction: both lanes share the divisor.
  typedef struct packed {
    logic             valid;
    logic             behind;
    logic             neg_x;
    logic             neg_y;
    logic [DIV_W-1:0] rem_x;
    logic [DIV_W-1:0] rem_y;
    logic [DIV_W-1:0] dsh;
    logic [Q_W-1:0]   q_x;
    logic [Q_W-1:0]   q_y;
  } cell_t;

  // Round half up by TRIG_FRAC_BITS and keep a term's width.
  function automatic term_t rnd_term(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + (ACC_W'(1) << (TRIG_FRAC_BITS - 1));
    return t[TRIG_FRAC_BITS+TERM_W-1:TRIG_FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/wpp_term_builder.sv
// Rotation term builder: sine/cosine of the three angles by Horner series,
// then the nine matrix terms, on one shared multiplier. Uses wpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpp_term_builder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start_i,
  input  wire logic [15:0]        angles_i [3],
  output logic                    busy_o,
  output wpp_pkg::term_t          terms_o [9]
);
  import wpp_pkg::*;

  localparam int MUL_W   = 33;
  localparam int TRIG_SH = 30 - TRIG_FRAC_BITS;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [3:0]  LAST_STEP = 4'd13;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_TH      = 13'b0000000000010,
    ST_TH_WB   = 13'b0000000000100,
    ST_T2      = 13'b0000000001000,
    ST_T2_WB   = 13'b0000000010000,
    ST_HMUL    = 13'b0000000100000,
    ST_HRCP    = 13'b0000001000000,
    ST_HWB     = 13'b0000010000000,
    ST_SMUL    = 13'b0000100000000,
    ST_SWB     = 13'b0001000000000,
    ST_ROUND   = 13'b0010000000000,
    ST_TMUL    = 13'b0100000000000,
    ST_TACC    = 13'b1000000000000
  } st_t;

  st_t   st_r, st_nxt;
  logic [1:0]  sel_r;
  logic [2:0]  k_r;
  logic        cos_r;
  logic [29:0] th_r, t2_r;
  logic [30:0] acc_r, sraw_r;
  logic [3:0]  step_r;
  logic signed [2*MUL_W-1:0] prod_r;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  term_t sn_r [3];
  term_t cs_r [3];
  term_t ab02_r, ab12_r;
  term_t terms_r [9];
  logic signed [ACC_W-1:0] sum_r, pv;

  logic [15:0] ang;
  logic [1:0]  quad;
  logic [13:0] ph, u;
  logic        flip;
  logic [14:0] comp;
  logic [2*MUL_W-1:0] th_sum, t2_sum;
  logic [36:0] rcp;
  logic [5:0]  rcp_sh;
  logic [30:0] rcp_m;
  logic [29:0] quo;
  logic [31:0] s_sum, c_sum;
  term_t s0, c0, sa, ca, sn_v, cs_v;

  // {shift, reciprocal} with reciprocal = ceil(2^shift / d) for each Horner
  // divisor d; exact floor(n / d) for any 30-bit n
  function automatic logic [36:0] horner_rcp(input logic is_cos, input logic [2:0] k);
    logic [36:0] r;
    r = {6'd31, 31'd1073741824};
    if (is_cos) begin
      unique case (k)
        3'd6: r = {6'd38, 31'd2082408386};
        3'd5: r = {6'd37, 31'd1527099484};
        3'd4: r = {6'd36, 31'd1227133514};
        3'd3: r = {6'd35, 31'd1145324613};
        3'd2: r = {6'd34, 31'd1431655766};
        default: r = {6'd31, 31'd1073741824};
      endcase
    end else begin
      unique case (k)
        3'd5: r = {6'd37, 31'd1249445032};
        3'd4: r = {6'd37, 31'd1908874354};
        3'd3: r = {6'd36, 31'd1636178018};
        3'd2: r = {6'd35, 31'd1717986919};
        default: r = {6'd33, 31'd1431655766};
      endcase
    end
    return r;
  endfunction

  assign ang  = angles_i[sel_r];
  assign quad = ang[15:14];
  assign ph   = ang[13:0];
  assign flip = ph > 14'd8192;
  assign comp = 15'd16384 - {1'b0, ph};
  assign u    = flip ? comp[13:0] : ph;

  assign th_sum = prod_r + (2*MUL_W)'(16384);
  assign t2_sum = prod_r + ((2*MUL_W)'(1) << 29);
  assign pv     = prod_r[ACC_W-1:0];

  assign rcp    = horner_rcp(cos_r, k_r);
  assign rcp_sh = rcp[36:31];
  assign rcp_m  = rcp[30:0];
  assign quo    = 30'($unsigned(prod_r) >> rcp_sh);

  // sin/cos rounded to the term format, then complement swap and quadrant
  assign s_sum = {1'b0, sraw_r} + (32'd1 << (TRIG_SH - 1));
  assign c_sum = {1'b0, acc_r} + (32'd1 << (TRIG_SH - 1));
  assign s0 = s_sum[TRIG_SH+TERM_W-1:TRIG_SH];
  assign c0 = c_sum[TRIG_SH+TERM_W-1:TRIG_SH];
  assign sa = flip ? c0 : s0;
  assign ca = flip ? s0 : c0;

  always_comb begin
    unique case (quad)
      2'd0: begin sn_v = sa;  cs_v = ca;  end
      2'd1: begin sn_v = ca;  cs_v = -sa; end
      2'd2: begin sn_v = -sa; cs_v = -ca; end
      default: begin sn_v = -ca; cs_v = sa; end
    endcase
  end

  // shared multiplier operands; sn_r[2] already holds the negated yaw sine
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_TH: begin
        mul_a = MUL_W'(u);
        mul_b = MUL_W'(PI_Q30);
      end
      ST_T2: begin
        mul_a = MUL_W'(th_r);
        mul_b = MUL_W'(th_r);
      end
      ST_HMUL: begin
        mul_a = MUL_W'(t2_r);
        mul_b = MUL_W'(acc_r);
      end
      ST_HRCP: begin
        mul_a = MUL_W'(prod_r[59:30]);
        mul_b = MUL_W'(rcp_m);
      end
      ST_SMUL: begin
        mul_a = MUL_W'(th_r);
        mul_b = MUL_W'(acc_r);
      end
      ST_TMUL: begin
        unique case (step_r)
          4'd0:  begin mul_a = MUL_W'(sn_r[0]); mul_b = MUL_W'(sn_r[1]); end
          4'd1:  begin mul_a = MUL_W'(cs_r[0]); mul_b = MUL_W'(sn_r[1]); end
          4'd2:  begin mul_a = MUL_W'(cs_r[0]); mul_b = MUL_W'(cs_r[2]); end
          4'd3:  begin mul_a = MUL_W'(ab02_r);  mul_b = MUL_W'(sn_r[2]); end
          4'd4:  begin mul_a = MUL_W'(sn_r[0]); mul_b = MUL_W'(cs_r[1]); end
          4'd5:  begin mul_a = MUL_W'(cs_r[0]); mul_b = MUL_W'(sn_r[2]); end
          4'd6:  begin mul_a = MUL_W'(ab02_r);  mul_b = MUL_W'(cs_r[2]); end
          4'd7:  begin mul_a = MUL_W'(sn_r[0]); mul_b = MUL_W'(cs_r[2]); end
          4'd8:  begin mul_a = MUL_W'(ab12_r);  mul_b = MUL_W'(sn_r[2]); end
          4'd9:  begin mul_a = MUL_W'(cs_r[0]); mul_b = MUL_W'(cs_r[1]); end
          4'd10: begin mul_a = MUL_W'(sn_r[0]); mul_b = MUL_W'(sn_r[2]); end
          4'd11: begin mul_a = MUL_W'(ab12_r);  mul_b = MUL_W'(cs_r[2]); end
          4'd12: begin mul_a = MUL_W'(cs_r[1]); mul_b = MUL_W'(sn_r[2]); end
          default: begin mul_a = MUL_W'(cs_r[1]); mul_b = MUL_W'(cs_r[2]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    if (start_i) st_nxt = ST_TH;
      ST_TH:      st_nxt = ST_TH_WB;
      ST_TH_WB:   st_nxt = ST_T2;
      ST_T2:      st_nxt = ST_T2_WB;
      ST_T2_WB:   st_nxt = ST_HMUL;
      ST_HMUL:    st_nxt = ST_HRCP;
      ST_HRCP:    st_nxt = ST_HWB;
      ST_HWB: begin
        if (k_r != 3'd1)  st_nxt = ST_HMUL;
        else if (cos_r)   st_nxt = ST_ROUND;
        else              st_nxt = ST_SMUL;
      end
      ST_SMUL:    st_nxt = ST_SWB;
      ST_SWB:     st_nxt = ST_HMUL;
      ST_ROUND:   st_nxt = (sel_r == 2'd2) ? ST_TMUL : ST_TH;
      ST_TMUL:    st_nxt = ST_TACC;
      ST_TACC:    st_nxt = (step_r == LAST_STEP) ? ST_IDLE : ST_TMUL;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int n = 0; n < 9; n++) begin
        terms_r[n] <= ((n % 4) == 0) ? (TERM_W'(1) << TRIG_FRAC_BITS) : '0;
      end
    end else begin
      st_r   <= st_nxt;
      prod_r <= mul_a * mul_b;
      unique case (st_r)
        ST_IDLE:  sel_r <= 2'd0;
        ST_TH_WB: th_r  <= th_sum[44:15];
        ST_T2_WB: begin
          t2_r  <= t2_sum[59:30];
          acc_r <= Q30_ONE;
          k_r   <= 3'd5;
          cos_r <= 1'b0;
        end
        ST_HWB: begin
          acc_r <= Q30_ONE - {1'b0, quo};
          k_r   <= k_r - 3'd1;
        end
        ST_SWB: begin
          sraw_r <= prod_r[60:30];
          acc_r  <= Q30_ONE;
          k_r    <= 3'd6;
          cos_r  <= 1'b1;
        end
        ST_ROUND: begin
          sn_r[sel_r] <= (sel_r == 2'd2) ? -sn_v : sn_v;
          cs_r[sel_r] <= cs_v;
          sel_r  <= (sel_r == 2'd2) ? 2'd0 : sel_r + 2'd1;
          step_r <= '0;
        end
        ST_TACC: begin
          step_r <= step_r + 4'd1;
          unique case (step_r)
            4'd0:  ab02_r     <= -rnd_term(pv);
            4'd1:  ab12_r     <= rnd_term(pv);
            4'd2:  sum_r      <= pv;
            4'd3:  terms_r[0] <= rnd_term(sum_r + pv);
            4'd4:  terms_r[1] <= -rnd_term(pv);
            4'd5:  sum_r      <= -pv;
            4'd6:  terms_r[2] <= rnd_term(sum_r + pv);
            4'd7:  sum_r      <= pv;
            4'd8:  terms_r[3] <= rnd_term(sum_r + pv);
            4'd9:  terms_r[4] <= rnd_term(pv);
            4'd10: sum_r      <= -pv;
            4'd11: terms_r[5] <= rnd_term(sum_r + pv);
            4'd12: terms_r[6] <= rnd_term(pv);
            default: begin
              terms_r[7] <= -sn_r[1];
              terms_r[8] <= rnd_term(pv);
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign busy_o  = (st_r != ST_IDLE);
  assign terms_o = terms_r;

endmodule

`default_nettype wire

FILE: hdl/wpp_div_cell.sv
// One cell of the divider row: one quotient bit for the x and y lanes,
// divisor shifted down for the next cell. Uses wpp_pkg::cell_t.
`timescale 1ns / 1ps
`default_nettype none

module wpp_div_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire wpp_pkg::cell_t cell_i,
  output wpp_pkg::cell_t      cell_o
);
  import wpp_pkg::*;

  cell_t cell_r;
  logic  ge_x, ge_y;

  assign ge_x = cell_i.rem_x >= cell_i.dsh;
  assign ge_y = cell_i.rem_y >= cell_i.dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid  <= cell_i.valid;
      cell_r.behind <= cell_i.behind;
      cell_r.neg_x  <= cell_i.neg_x;
      cell_r.neg_y  <= cell_i.neg_y;
      cell_r.rem_x  <= ge_x ? cell_i.rem_x - cell_i.dsh : cell_i.rem_x;
      cell_r.rem_y  <= ge_y ? cell_i.rem_y - cell_i.dsh : cell_i.rem_y;
      cell_r.dsh    <= cell_i.dsh >> 1;
      cell_r.q_x    <= {cell_i.q_x[Q_W-2:0], ge_x};
      cell_r.q_y    <= {cell_i.q_y[Q_W-2:0], ge_y};
    end
  end

  assign cell_o = cell_r;

endmodule

`default_nettype wire

FILE: hdl/world_to_pixel_projection_top.sv
// World-to-pixel projection top: config registers, rotation and focal
// pipeline, divider cell row, saturation. Uses wpp_pkg, wpp_term_builder, wpp_div_cell.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | start, busy             | in_point_x/y/z (32b signed)
//  result   | out_valid (1-cycle)     | out_pixel_x/y (16b signed), out_behind, out_clipped
//  config   | cfg_valid, cfg_ready    | cfg_index (3b), cfg_data (24b)
//
// One point per cycle while busy is low; results leave in order on out_valid.
// An angle write rebuilds the matrix on the builder's shared multiplier
// (series and reciprocal divide): busy and not cfg_ready until the rebuild is done.
// Synchronous reset loads register defaults and the identity matrix.
// The result side cannot stall; the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module world_to_pixel_projection_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [31:0]       in_point_x,
  input  wire logic signed [31:0]       in_point_y,
  input  wire logic signed [31:0]       in_point_z,
  output logic                          out_valid,
  output logic signed [15:0]            out_pixel_x,
  output logic signed [15:0]            out_pixel_y,
  output logic                          out_behind,
  output logic                          out_clipped,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [wpp_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [wpp_pkg::CFG_W-1:0] cfg_data
);
  import wpp_pkg::*;

  localparam int SUM_W = QBITS + 2;

  logic [ANG_W-1:0]   ang_r [3];
  logic [FOCAL_W-1:0] fx_r, fy_r;
  logic [DIM_W-1:0]   wid_r, hei_r;
  logic cfg_wr, ang_wr, bld_busy;
  term_t terms [9];

  logic signed [PT_W-1:0]   pt_r [3];
  logic signed [PROD_W-1:0] pr_r [9];
  logic signed [ROT_W-1:0]  rot_r [3];
  logic signed [NUM_W-1:0]  nx_r, ny_r;
  logic [DEN_W-1:0]         den_r;
  logic v0_r, v1_r, v2_r, v3_r, bh3_r;
  logic [MAG_W-1:0] mag_x, mag_y;
  cell_t c_in_r;
  cell_t chain [NCELLS+1];
  logic [16:0] fin_x, fin_y;

  function automatic logic [16:0] fin_coord(input logic neg, input logic [Q_W-1:0] q,
                                            input logic [DIM_W-2:0] half);
    logic signed [SUM_W-1:0] mag, s;
    mag = SUM_W'(q[QBITS-1:0]);
    if (neg) mag = -mag;
    s = mag + SUM_W'(half);
    if (q[QBITS])      return neg ? {1'b1, 16'h8000} : {1'b1, 16'h7FFF};
    else if (s > 32767)  return {1'b1, 16'h7FFF};
    else if (s < -32768) return {1'b1, 16'h8000};
    else               return {1'b0, s[15:0]};
  endfunction

  assign cfg_ready = !bld_busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign ang_wr    = cfg_wr && (cfg_index == REG_ROLL || cfg_index == REG_PITCH ||
                                cfg_index == REG_YAW);
  assign busy      = bld_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r[0] <= '0;
      ang_r[1] <= '0;
      ang_r[2] <= '0;
      fx_r  <= FOCAL_W'(256);
      fy_r  <= FOCAL_W'(256);
      wid_r <= DIM_W'(640);
      hei_r <= DIM_W'(480);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ROLL:   ang_r[0] <= cfg_data[ANG_W-1:0];
        REG_PITCH:  ang_r[1] <= cfg_data[ANG_W-1:0];
        REG_YAW:    ang_r[2] <= cfg_data[ANG_W-1:0];
        REG_FOCALX: fx_r  <= cfg_data[FOCAL_W-1:0];
        REG_FOCALY: fy_r  <= cfg_data[FOCAL_W-1:0];
        REG_WIDTH:  wid_r <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: hei_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  wpp_term_builder u_builder (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (ang_wr),
    .angles_i (ang_r),
    .busy_o   (bld_busy),
    .terms_o  (terms)
  );

  // input register and the nine rotation products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      if (start && !busy) begin
        pt_r[0] <= in_point_x;
        pt_r[1] <= in_point_y;
        pt_r[2] <= in_point_z;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        pr_r[3*i+j] <= pt_r[i] * terms[3*i+j];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_rot
    logic signed [SUM3_W-1:0] s3;
    assign s3 = SUM3_W'(pr_r[j]) + SUM3_W'(pr_r[3+j]) + SUM3_W'(pr_r[6+j])
              + (SUM3_W'(1) << (TRIG_FRAC_BITS - 1));
    always_ff @(posedge clk) begin
      rot_r[j] <= s3[SUM3_W-1:TRIG_FRAC_BITS];
    end
  end

  // focal products and divisor; depth <= 0 marks the point behind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      bh3_r <= rot_r[2][ROT_W-1] || (rot_r[2] == '0);
      nx_r  <= $signed({1'b0, fx_r}) * rot_r[0];
      ny_r  <= $signed({1'b0, fy_r}) * rot_r[1];
      den_r <= {rot_r[2][ROT_W-2:0], {FOCAL_FRAC_BITS{1'b0}}};
    end
  end

  assign mag_x = nx_r[NUM_W-1] ? MAG_W'(-nx_r) : nx_r[MAG_W-1:0];
  assign mag_y = ny_r[NUM_W-1] ? MAG_W'(-ny_r) : ny_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_in_r.valid <= 1'b0;
    end else begin
      c_in_r.valid  <= v3_r;
      c_in_r.behind <= bh3_r;
      c_in_r.neg_x  <= nx_r[NUM_W-1];
      c_in_r.neg_y  <= ny_r[NUM_W-1];
      c_in_r.rem_x  <= DIV_W'(mag_x);
      c_in_r.rem_y  <= DIV_W'(mag_y);
      c_in_r.dsh    <= DIV_W'(den_r) << QBITS;
      c_in_r.q_x    <= '0;
      c_in_r.q_y    <= '0;
    end
  end

  assign chain[0] = c_in_r;

  // first cell's bit flags a quotient too large for the pixel range
  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    wpp_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (chain[c]),
      .cell_o (chain[c+1])
    );
  end

  assign fin_x = fin_coord(chain[NCELLS].neg_x, chain[NCELLS].q_x, wid_r[DIM_W-1:1]);
  assign fin_y = fin_coord(chain[NCELLS].neg_y, chain[NCELLS].q_y, hei_r[DIM_W-1:1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= chain[NCELLS].valid;
      if (chain[NCELLS].behind) begin
        out_pixel_x <= -16'sd1;
        out_pixel_y <= -16'sd1;
        out_behind  <= 1'b1;
        out_clipped <= 1'b0;
      end else begin
        out_pixel_x <= fin_x[15:0];
        out_pixel_y <= fin_y[15:0];
        out_behind  <= 1'b0;
        out_clipped <= fin_x[16] | fin_y[16];
      end
    end
  end

  a_ang_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ang_wr |=> busy)
    else $error("angle write did not start a matrix rebuild");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(ang_wr))
    else $error("rebuild started without an angle write");

  a_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_behind) |-> (out_pixel_x == -16'sd1 && out_pixel_y == -16'sd1
                                   && !out_clipped))
    else $error("behind result with wrong payload");

  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready)
    else $error("config accepted during rebuild");

endmodule

`default_nettype wire

FILE: dv/tb_world_to_pixel_projection_top.sv
// Self-checking testbench for world_to_pixel_projection_top: directed and random points
// across several camera settings, checked against a bit-exact projection predictor.
// Depends on wpp_pkg and the block's RTL.
`timescale 1ns / 1ps

class pixel_scoreboard;
  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               behind;
    logic               clipped;
  } pixel_t;

  pixel_t      pending[$];
  int          n_err;
  logic [15:0] roll, pitch, yaw;
  longint      focal_x, focal_y, width, height;
  longint      terms[9];

  function new();
    n_err   = 0;
    roll    = 0;
    pitch   = 0;
    yaw     = 0;
    focal_x = 256;
    focal_y = 256;
    width   = 640;
    height  = 480;
    build_terms();
  endfunction

  // Round half up by 16 fraction bits (floor of the biased value).
  function longint rshift(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function void sin_cos(logic [15:0] ang, output longint sn, output longint cs);
    longint unsigned ph, u, th, t2, s, c, one;
    longint          s0, c0, tmp;
    bit              flip;
    one  = 64'd1 << 30;
    ph   = ang & 16'h3FFF;
    flip = ph > 8192;
    u    = flip ? 16384 - ph : ph;
    th   = (u * 64'd3373259426 + 16384) >> 15;
    t2   = (th * th + (64'd1 << 29)) >> 30;
    s    = one;
    c    = one;
    for (int k = 5; k >= 1; k--) s = one - ((t2 * s) >> 30) / ((2 * k) * (2 * k + 1));
    s = (th * s) >> 30;
    for (int k = 6; k >= 1; k--) c = one - ((t2 * c) >> 30) / ((2 * k - 1) * (2 * k));
    s0 = longint'((s + (64'd1 << 13)) >> 14);
    c0 = longint'((c + (64'd1 << 13)) >> 14);
    if (flip) begin
      tmp = s0;
      s0  = c0;
      c0  = tmp;
    end
    case (ang[15:14])
      2'd0: begin sn = s0;  cs = c0;  end
      2'd1: begin sn = c0;  cs = -s0; end
      2'd2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endfunction

  function void build_terms();
    longint sr, cr, sp, cp, sy, cy, ab02, ab12;
    sin_cos(roll, sr, cr);
    sin_cos(pitch, sp, cp);
    sin_cos(yaw, sy, cy);
    sy       = -sy;  // yaw enters negated
    ab02     = -rshift(sr * sp);
    ab12     = rshift(cr * sp);
    terms[0] = rshift(cr * cy + ab02 * sy);
    terms[1] = -rshift(sr * cp);
    terms[2] = rshift(-cr * sy + ab02 * cy);
    terms[3] = rshift(sr * cy + ab12 * sy);
    terms[4] = rshift(cr * cp);
    terms[5] = rshift(-sr * sy + ab12 * cy);
    terms[6] = rshift(cp * sy);
    terms[7] = -sp;
    terms[8] = rshift(cp * cy);
  endfunction

  function void set_reg(logic [2:0] idx, logic [23:0] data);
    case (idx)
      wpp_pkg::REG_ROLL:   begin roll = data[15:0];  build_terms(); end
      wpp_pkg::REG_PITCH:  begin pitch = data[15:0]; build_terms(); end
      wpp_pkg::REG_YAW:    begin yaw = data[15:0];   build_terms(); end
      wpp_pkg::REG_FOCALX: focal_x = data;
      wpp_pkg::REG_FOCALY: focal_y = data;
      wpp_pkg::REG_WIDTH:  width = data[13:0];
      wpp_pkg::REG_HEIGHT: height = data[13:0];
      default: ;
    endcase
  endfunction

  function longint clamp16(longint v, inout logic clip);
    if (v > 32767) begin
      clip = 1;
      return 32767;
    end
    if (v < -32768) begin
      clip = 1;
      return -32768;
    end
    return v;
  endfunction

  function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
    longint p[3], r[3], den, qx, qy;
    pixel_t e;
    p[0] = x;
    p[1] = y;
    p[2] = z;
    for (int j = 0; j < 3; j++)
      r[j] = rshift(p[0] * terms[j] + p[1] * terms[3 + j] + p[2] * terms[6 + j]);
    if (r[2] <= 0) begin
      e.px      = -16'sd1;
      e.py      = -16'sd1;
      e.behind  = 1;
      e.clipped = 0;
    end else begin
      e.behind  = 0;
      e.clipped = 0;
      den       = r[2] * 256;
      qx        = (focal_x * r[0]) / den + width / 2;
      qy        = (focal_y * r[1]) / den + height / 2;
      e.px      = 16'(clamp16(qx, e.clipped));
      e.py      = 16'(clamp16(qy, e.clipped));
    end
    pending.push_back(e);
  endfunction

  function void check_pixel(logic signed [15:0] px, logic signed [15:0] py,
                            logic behind, logic clipped);
    pixel_t e;
    if (pending.size() == 0) begin
      $error("result with no transaction outstanding");
      n_err++;
      return;
    end
    e = pending.pop_front();
    if (px !== e.px) begin
      $error("pixel_x expected %0d actual %0d", e.px, px);
      n_err++;
    end
    if (py !== e.py) begin
      $error("pixel_y expected %0d actual %0d", e.py, py);
      n_err++;
    end
    if (behind !== e.behind) begin
      $error("behind expected %0d actual %0d", e.behind, behind);
      n_err++;
    end
    if (clipped !== e.clipped) begin
      $error("clipped expected %0d actual %0d", e.clipped, clipped);
      n_err++;
    end
  endfunction
endclass

module tb_world_to_pixel_projection_top;
  import wpp_pkg::*;

  logic               clk, rst_n, start, busy;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic               out_valid, out_behind, out_clipped;
  logic signed [15:0] out_pixel_x, out_pixel_y;
  logic               cfg_valid, cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  pixel_scoreboard sb;
  int              idle_pct;

  world_to_pixel_projection_top u_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_world_to_pixel_projection_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_point(in_point_x, in_point_y, in_point_z);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (out_valid) sb.check_pixel(out_pixel_x, out_pixel_y, out_behind, out_clipped);
    end
  end

  // each cycle idles with probability idle_pct percent before the transaction
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start      <= 1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Mostly points in front of the camera at moderate scale; some raw noise.
  task automatic random_point();
    int sel;
    logic signed [31:0] x, y, z;
    sel = $urandom_range(9);
    if (sel < 2) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else begin
      x = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      y = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      z = (sel < 4) ? $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000
                    : $signed($urandom_range(1, 32'h00FF_FFFF));
    end
    send_point(x, y, z);
  endtask

  task automatic set_camera(int n);
    logic [15:0] r, p, w;
    r = $urandom;
    p = $urandom;
    w = $urandom;
    drain();
    case (n)
      0: begin
        write_reg(REG_ROLL, 24'h008000);
        write_reg(REG_PITCH, 24'h007FFF);
        write_reg(REG_YAW, 24'h0);
        write_reg(REG_FOCALX, 24'hFFFFFF);
        write_reg(REG_FOCALY, 24'h0);
        write_reg(REG_WIDTH, 24'd1);
        write_reg(REG_HEIGHT, 24'd8192);
      end
      1: begin
        write_reg(REG_ROLL, 24'h0);
        write_reg(REG_PITCH, 24'h0);
        write_reg(REG_YAW, 24'h008000);
        write_reg(REG_FOCALX, 24'h0);
        write_reg(REG_FOCALY, 24'hFFFFFF);
        write_reg(REG_WIDTH, 24'd8192);
        write_reg(REG_HEIGHT, 24'd1);
      end
      default: begin
        write_reg(REG_ROLL, {8'h0, r});
        write_reg(REG_PITCH, {8'h0, p});
        write_reg(REG_YAW, {8'h0, w});
        write_reg(REG_FOCALX, CFG_W'($urandom_range(0, 24'h0FFFFF)));
        write_reg(REG_FOCALY, CFG_W'($urandom_range(0, 24'h0FFFFF)));
        write_reg(REG_WIDTH, CFG_W'($urandom_range(1, 8192)));
        write_reg(REG_HEIGHT, CFG_W'($urandom_range(1, 8192)));
      end
    endcase
  endtask

  initial begin
    int guard;
    sb         = new();
    rst_n      = 0;
    start      = 0;
    in_point_x = 0;
    in_point_y = 0;
    in_point_z = 0;
    cfg_valid  = 0;
    cfg_index  = REG_ROLL;
    cfg_data   = 0;
    idle_pct   = 24;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: identity camera at reset defaults
    send_point(0, 0, 0);                                   // zero depth
    send_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000); // behind
    send_point(0, 0, 32'sh0001_0000);                      // center
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1);    // clip both ways
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1);
    send_point(32'sh0010_0000, -32'sh0008_0000, 32'sh0002_0000);
    send_point(-32'sd1, -32'sd1, 32'sd1);
    send_point(32'sd1, 32'sd1, 32'sh7FFF_FFFF);

    for (int n = 0; n < 6; n++) begin
      idle_pct = (n < 2) ? 24 : (n < 4) ? 50 : 0;
      set_camera(n);
      for (int i = 0; i < 330; i++) random_point();
    end

    start <= 0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("tb_world_to_pixel_projection_top: PASS");
    end else begin
      $display("tb_world_to_pixel_projection_top: FAIL");
    end
    $finish;
  end
endmodule
